// ----- rtl/str_esc_pkg.sv -----
package str_esc_pkg;

  localparam int CODE_W = 16;
  localparam int CHAR_W = 7;
  localparam int NIB_W  = 4;
  localparam int IDX_W  = 3;

  localparam logic [CODE_W-1:0] CODE_BSLASH = 16'h005C;
  localparam logic [CODE_W-1:0] CODE_LF     = 16'h000A;
  localparam logic [CODE_W-1:0] CODE_CR     = 16'h000D;
  localparam logic [CODE_W-1:0] CODE_QUOTE  = 16'h0022;
  localparam logic [CODE_W-1:0] CODE_SPACE  = 16'h0020;
  localparam logic [CODE_W-1:0] CODE_TILDE  = 16'h007E;

  localparam logic [CHAR_W-1:0] CH_BSLASH = 7'h5C;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 7'h22;
  localparam logic [CHAR_W-1:0] CH_N      = 7'h6E;
  localparam logic [CHAR_W-1:0] CH_R      = 7'h72;
  localparam logic [CHAR_W-1:0] CH_U      = 7'h75;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CH_A      = 7'h61;

  // position of a character within the escaped run
  localparam logic [IDX_W-1:0] IDX_LEAD   = 3'd0;
  localparam logic [IDX_W-1:0] IDX_SECOND = 3'd1;
  localparam logic [IDX_W-1:0] IDX_HEX3   = 3'd2;
  localparam logic [IDX_W-1:0] IDX_HEX2   = 3'd3;
  localparam logic [IDX_W-1:0] IDX_HEX1   = 3'd4;
  localparam logic [IDX_W-1:0] IDX_HEX0   = 3'd5;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } fmt_out_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
    logic [CHAR_W-1:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + CHAR_W'(nib);
    end else begin
      ch = CH_A + CHAR_W'(nib - 4'd10);
    end
    return ch;
  endfunction

endpackage

// ----- rtl/str_esc_fmt.sv -----
module str_esc_fmt (
  input  logic [str_esc_pkg::CODE_W-1:0] code,
  input  logic [str_esc_pkg::IDX_W-1:0]  idx,
  output str_esc_pkg::fmt_out_t          fmt
);

  logic                             is_plain;
  logic                             is_short;
  logic [str_esc_pkg::CHAR_W-1:0]   short_ch;

  always_comb begin
    is_plain = (code >= str_esc_pkg::CODE_SPACE) && (code <= str_esc_pkg::CODE_TILDE)
               && (code != str_esc_pkg::CODE_BSLASH) && (code != str_esc_pkg::CODE_QUOTE);
    is_short = 1'b1;
    short_ch = str_esc_pkg::CH_BSLASH;
    priority if (code == str_esc_pkg::CODE_BSLASH) begin
      short_ch = str_esc_pkg::CH_BSLASH;
    end else if (code == str_esc_pkg::CODE_LF) begin
      short_ch = str_esc_pkg::CH_N;
    end else if (code == str_esc_pkg::CODE_CR) begin
      short_ch = str_esc_pkg::CH_R;
    end else if (code == str_esc_pkg::CODE_QUOTE) begin
      short_ch = str_esc_pkg::CH_QUOTE;
    end else begin
      is_short = 1'b0;
    end
  end

  always_comb begin
    fmt.ch   = str_esc_pkg::CH_BSLASH;
    fmt.last = 1'b0;
    unique case (idx)
      str_esc_pkg::IDX_LEAD: begin
        if (is_plain) begin
          fmt.ch   = code[str_esc_pkg::CHAR_W-1:0];
          fmt.last = 1'b1;
        end
      end
      str_esc_pkg::IDX_SECOND: begin
        if (is_short) begin
          fmt.ch   = short_ch;
          fmt.last = 1'b1;
        end else begin
          fmt.ch = str_esc_pkg::CH_U;
        end
      end
      str_esc_pkg::IDX_HEX3: fmt.ch = str_esc_pkg::hex_char(code[15:12]);
      str_esc_pkg::IDX_HEX2: fmt.ch = str_esc_pkg::hex_char(code[11:8]);
      str_esc_pkg::IDX_HEX1: fmt.ch = str_esc_pkg::hex_char(code[7:4]);
      str_esc_pkg::IDX_HEX0: begin
        fmt.ch   = str_esc_pkg::hex_char(code[3:0]);
        fmt.last = 1'b1;
      end
      default: begin
        fmt.ch   = str_esc_pkg::CH_BSLASH;
        fmt.last = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/string_escape_encoder_top.sv -----
// string escape encoder
// input channel: in_valid / in_stall carry one 16-bit character code per beat
// on in_char. output channel: out_valid / out_stall carry one 7-bit ascii
// character per beat on out_char, with out_last high on the final character
// of the escaped run for that input.
// runs are 1 character (printable ascii), 2 (backslash, lf, cr, quote) or
// 6 (backslash, u and four lowercase hex digits) beats long.
// latency: the first character of a code passes the input register and then the
// output register before it is offered on out_char.
// throughput: one output beat per cycle while out_stall is low, so plain text
// runs at one code per cycle. the input register holds the code being expanded
// and the output register holds the character on offer, so a new code is taken
// in the same cycle the previous run's last character moves to the output.
// reset (rst_n low, synchronous) empties both registers; no other state.
// while out_stall is high the offered character holds, and once the input
// register has work left in_stall is raised as well.
module string_escape_encoder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [str_esc_pkg::CODE_W-1:0]  in_char,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [str_esc_pkg::CHAR_W-1:0]  out_char,
  output logic                            out_last
);

  logic                            cur_valid_r, cur_valid_nxt;
  logic [str_esc_pkg::IDX_W-1:0]   cur_idx_r, cur_idx_nxt;
  logic [str_esc_pkg::CODE_W-1:0]  cur_code_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [str_esc_pkg::CHAR_W-1:0]  out_char_r;
  logic                            out_last_r;

  str_esc_pkg::fmt_out_t           fmt;
  logic                            out_load;
  logic                            adv;
  logic                            done;
  logic                            accept;

  str_esc_fmt u_fmt (
    .code (cur_code_r),
    .idx  (cur_idx_r),
    .fmt  (fmt)
  );

  assign out_load = !out_valid_r || !out_stall;
  assign adv      = cur_valid_r && out_load;
  assign done     = adv && fmt.last;
  assign in_stall = cur_valid_r && !done;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_idx_nxt   = cur_idx_r;
    if (accept) begin
      cur_valid_nxt = 1'b1;
      cur_idx_nxt   = str_esc_pkg::IDX_LEAD;
    end else if (done) begin
      cur_valid_nxt = 1'b0;
    end else if (adv) begin
      cur_idx_nxt = cur_idx_r + str_esc_pkg::IDX_W'(1);
    end
    out_valid_nxt = out_load ? cur_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_idx_r   <= str_esc_pkg::IDX_LEAD;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      cur_idx_r   <= cur_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_code_r <= in_char;
    end
    if (adv) begin
      out_char_r <= fmt.ch;
      out_last_r <= fmt.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // run position never passes the last hex digit
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> cur_idx_r <= str_esc_pkg::IDX_HEX0)
    else $error("run index out of range");

  // an accepted beat starts a fresh run
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> cur_valid_r && cur_idx_r == str_esc_pkg::IDX_LEAD)
    else $error("accepted code did not start a run");

  // a non-final character keeps the run and steps the index
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !fmt.last |=> cur_valid_r
                         && cur_idx_r == $past(cur_idx_r) + str_esc_pkg::IDX_W'(1))
    else $error("run did not advance");

  // input is never taken while a run still has characters left
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r && !done |-> !accept)
    else $error("input taken mid run");

endmodule
